// ===== sv/cdme_pkg.sv =====
// Package: card codes, mill modes, field widths and constants for the card-driven mill.
`timescale 1ns / 1ps
package cdme_pkg;
  localparam int unsigned StoreDepthDefault = 1024;
  localparam logic [31:0] LeverLimitReset = 32'sd55;

  localparam logic [3:0] OP_NUMBER = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_LOAD   = 4'd5;
  localparam logic [3:0] OP_LOADZ  = 4'd6;
  localparam logic [3:0] OP_STORE  = 4'd7;
  localparam logic [3:0] OP_JUMP   = 4'd8;
  localparam logic [3:0] OP_BEEP   = 4'd9;
  localparam logic [3:0] OP_HALT   = 4'd10;
  localparam logic [3:0] OP_PRINT  = 4'd11;

  localparam logic [2:0] MODE_NULL = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  localparam logic [1:0] DIR_BACK = 2'd1;
  localparam logic [1:0] DIR_FWD  = 2'd2;
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_LEVER  = 2'd1;

  typedef struct packed {
    logic [3:0]  operation;
    logic [9:0]  slot;
    logic [31:0] value;
    logic [1:0]  jump_direction;
    logic [1:0]  jump_condition;
  } card_t;

  typedef struct packed {
    logic [31:0] egress_value;
    logic        print_valid;
    logic        beep;
    logic        halted;
    logic        jump_taken;
    logic [31:0] jump_offset;
    logic        lever;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // clearing pass write
    logic card_load;   // latch card, issue store read
    logic exec;        // apply card with read data
    logic div_start;
    logic div_step;
    logic div_finish;
    logic mul_finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic needs_div;
    logic needs_mul;
    logic div_last;
  } dp_sts_t;
endpackage

// ===== sv/cdme_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/cdme_datapath.sv =====
// Datapath: store, axes, lever, serial divider, multiplier and result register.
`timescale 1ns / 1ps
module cdme_datapath #(
  parameter int unsigned StoreDepth = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             limit_i,
  input  cdme_pkg::card_t         card_i,
  input  cdme_pkg::dp_cmd_t       cmd_i,
  output cdme_pkg::dp_sts_t       sts_o,
  output cdme_pkg::result_t       res_o
);
  import cdme_pkg::*;
  localparam int unsigned AW = $clog2(StoreDepth);

  card_t       card_q;
  logic [31:0] ingress_q, egress_q, egress_d;
  logic        phase_q, lever_q, lever_d, halt_q;
  logic [2:0]  mode_q;
  logic [AW:0] clr_q;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0] ram_wdata, rdata;
  logic        idx_ok, is_load, calc;

  // result flags
  logic        prt_q, bp_q, hlt_q, tkn_q;
  logic [31:0] ofs_q;

  // divider
  logic [31:0] quo_q, rem_q, dvs_q;
  logic        neg_q;
  logic [4:0]  dcnt_q;
  logic [32:0] rem_sh, rem_sub;
  logic [63:0] prod_q;

  assign idx_ok = ({22'd0, card_q.slot} < 32'(StoreDepth));
  assign is_load = (card_q.operation == OP_LOAD) || (card_q.operation == OP_LOADZ);
  assign calc = is_load && idx_ok && phase_q && !halt_q;

  assign sts_o.clr_done  = clr_q[AW];
  assign sts_o.needs_div = calc && (mode_q == MODE_DIV);
  assign sts_o.needs_mul = calc && (mode_q == MODE_MUL);
  assign sts_o.div_last  = (dcnt_q == 5'd31);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = AW'(card_q.slot);
    ram_wdata = '0;
    if (!clr_q[AW]) begin
      ram_we = cmd_i.clr_step;
      ram_waddr = clr_q[AW-1:0];
    end else if (cmd_i.exec && !halt_q && idx_ok) begin
      case (card_q.operation)
        OP_NUMBER: begin ram_we = 1'b1; ram_wdata = card_q.value; end
        OP_STORE:  begin ram_we = 1'b1; ram_wdata = egress_q; end
        OP_LOADZ:  ram_we = 1'b1;
        default:   ram_we = 1'b0;
      endcase
    end
  end

  cdme_ram #(.Width(32), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(AW'(card_i.slot)), .rdata_o(rdata)
  );

  // add / sub results
  logic [31:0] sum, dif;
  assign sum = ingress_q + rdata;
  assign dif = ingress_q - rdata;

  always_comb begin
    egress_d = egress_q;
    lever_d  = lever_q;
    if (cmd_i.div_finish) begin
      egress_d = (dvs_q == '0) ? '0 : (neg_q ? -quo_q : quo_q);
      lever_d = 1'b0;
    end else if (cmd_i.mul_finish) begin
      egress_d = prod_q[31:0];
      lever_d = 1'b0;
    end else if (cmd_i.exec && calc) begin
      case (mode_q)
        MODE_ADD: begin
          egress_d = sum;
          lever_d = !((!ingress_q[31] && ingress_q != 0 && sum[31]) ||
                      (ingress_q[31] && !sum[31] && sum != 0) ||
                      ($signed(sum) > $signed(limit_i)));
        end
        MODE_SUB: begin
          egress_d = dif;
          lever_d = $signed(ingress_q) < $signed(rdata);
        end
        default: ;
      endcase
    end
  end

  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; ingress_q <= '0; egress_q <= '0; phase_q <= 1'b0;
      lever_q <= 1'b0; halt_q <= 1'b0; mode_q <= MODE_NULL; dcnt_q <= '0;
    end else begin
      if (cmd_i.clr_step && !clr_q[AW]) clr_q <= clr_q + 1'b1;
      egress_q <= egress_d;
      lever_q <= lever_d;
      if (cmd_i.exec && !halt_q) begin
        case (card_q.operation)
          OP_ADD: mode_q <= MODE_ADD;
          OP_SUB: mode_q <= MODE_SUB;
          OP_MUL: mode_q <= MODE_MUL;
          OP_DIV: mode_q <= MODE_DIV;
          OP_HALT: halt_q <= 1'b1;
          OP_LOAD, OP_LOADZ: if (idx_ok) begin
            if (!phase_q) ingress_q <= rdata;
            phase_q <= !phase_q;
          end
          default: ;
        endcase
      end
      if (cmd_i.div_start) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.card_load) card_q <= card_i;
    if (cmd_i.exec) prod_q <= ingress_q * rdata;
    if (cmd_i.div_start) begin
      quo_q <= ingress_q[31] ? -ingress_q : ingress_q;
      dvs_q <= rdata[31] ? -rdata : rdata;
      neg_q <= ingress_q[31] ^ rdata[31];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0]; quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0]; quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.exec) begin
      prt_q <= !halt_q && card_q.operation == OP_PRINT;
      bp_q <= !halt_q && card_q.operation == OP_BEEP;
      hlt_q <= halt_q || card_q.operation == OP_HALT;
      tkn_q <= 1'b0;
      ofs_q <= 32'd1;
      if (!halt_q && card_q.operation == OP_JUMP &&
          (card_q.jump_condition == COND_ALWAYS ||
           (card_q.jump_condition == COND_LEVER && lever_q))) begin
        tkn_q <= 1'b1;
        ofs_q <= (card_q.jump_direction == DIR_BACK) ? -card_q.value :
                 (card_q.jump_direction == DIR_FWD) ? card_q.value : 32'd0;
      end
    end
  end

  assign res_o = '{egress_value: egress_q, print_valid: prt_q, beep: bp_q,
                   halted: hlt_q, jump_taken: tkn_q, jump_offset: ofs_q,
                   lever: lever_q};
endmodule

// ===== sv/cdme_ctrl.sv =====
// Controller: clearing pass, card sequencing, divide/multiply waits, output handshake.
`timescale 1ns / 1ps
module cdme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cdme_pkg::dp_sts_t sts_i,
  output cdme_pkg::dp_cmd_t cmd_o
);
  import cdme_pkg::*;
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_EXEC = 3'd2,
                         S_DIV = 3'd3, S_MUL = 3'd4, S_OUT = 3'd5;
  logic [2:0] state_q, state_d;
  logic div_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: if (in_valid_i) begin
        cmd_o.card_load = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.needs_div) begin cmd_o.div_start = 1'b1; state_d = S_DIV; end
        else if (sts_i.needs_mul) state_d = S_MUL;
        else state_d = S_OUT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MUL;
      end
      S_MUL: state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // finish cycle: S_MUL serves both multiply and divide results
    cmd_o.div_finish = (state_q == S_MUL) && div_q;
    cmd_o.mul_finish = (state_q == S_MUL) && !div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; div_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.div_start) div_q <= 1'b1;
      else if (state_q == S_MUL) div_q <= 1'b0;
    end
  end
endmodule

// ===== sv/card_driven_mill_executor_top.sv =====
// Top level of the card-driven mill executor.
// Channel | Dir | Transfer content
// s_axis  | in  | tuser: operation; tdata: slot, value, jump_direction, jump_condition
// m_axis  | out | tdata: egress_value, jump_offset;
//         |     | tuser: print_valid, beep, halted, jump_taken, lever
// cfg     | in  | add_lever_limit
// States per card: IDLE, EXEC, OUT; multiply adds MUL; serial divide adds DIV and MUL.
// After reset a clearing pass zeroes the store; no cards are taken then.
// The result register holds until m_axis_tready; no new card is taken meanwhile.
`timescale 1ns / 1ps
module card_driven_mill_executor_top #(
  parameter int unsigned STORE_DEPTH = cdme_pkg::StoreDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // slot[9:0] value[41:10] dir[43:42] cond[45:44]
  input  logic [3:0]  s_axis_tuser,  // operation[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // egress_value[31:0] jump_offset[63:32]
  output logic [4:0]  m_axis_tuser,  // print_valid beep halted jump_taken lever
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import cdme_pkg::*;
  card_t card;
  result_t res;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [31:0] limit_q;

  assign card.operation      = s_axis_tuser;
  assign card.slot           = s_axis_tdata[9:0];
  assign card.value          = s_axis_tdata[41:10];
  assign card.jump_direction = s_axis_tdata[43:42];
  assign card.jump_condition = s_axis_tdata[45:44];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LeverLimitReset;
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end

  cdme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  cdme_datapath #(.StoreDepth(STORE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .limit_i(limit_q), .card_i(card), .cmd_i(cmd),
    .sts_o(sts), .res_o(res)
  );

  assign m_axis_tdata = {res.jump_offset, res.egress_value};
  assign m_axis_tuser = {res.lever, res.jump_taken, res.halted, res.beep, res.print_valid};
endmodule

// ===== sv/cdme_checker.sv =====
// Port-level checker for the mill executor, bound to the top level.
`timescale 1ns / 1ps
module cdme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |=> !m_axis_tvalid || m_axis_tuser[2])
    else $error("halted flag dropped");
  a_untaken_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata[63:32] == 32'd1)
    else $error("offset not one on untaken jump");
  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[3:0] == 4'b0100)
    else $error("flags raised after halt");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second card taken");
endmodule

bind card_driven_mill_executor_top cdme_checker u_cdme_checker (.*);

// ===== verif/card_driven_mill_executor_checker.sv =====
// Checker for the card-driven mill: predicts each result from the accepted cards and compares.
`timescale 1ns / 1ps
module card_driven_mill_executor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [4:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);
  import cdme_pkg::*;

  logic [31:0] mem_q [1024];
  logic [31:0] ingress_q, egress_q, limit_q;
  logic        phase_q, lever_q, halted_q;
  logic [2:0]  mode_q;
  result_t     result_q [$];
  int          err_cnt;

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %t %s: got %h want %h", $realtime, field, got, want);
    err_cnt++;
  endtask

  function automatic void mill_calc(input logic [31:0] operand);
    logic [31:0] sum;
    longint      quot;
    case (mode_q)
      MODE_ADD: begin
        sum = ingress_q + operand;
        egress_q = sum;
        lever_q = !(($signed(ingress_q) > 0 && $signed(sum) < 0) ||
                    ($signed(ingress_q) < 0 && $signed(sum) > 0) ||
                    ($signed(sum) > $signed(limit_q)));
      end
      MODE_SUB: begin
        egress_q = ingress_q - operand;
        lever_q = $signed(ingress_q) < $signed(operand);
      end
      MODE_MUL: begin
        egress_q = ingress_q * operand;
        lever_q = 1'b0;
      end
      MODE_DIV: begin
        if (operand == 32'd0) begin
          egress_q = 32'd0;
        end else begin
          quot = longint'($signed(ingress_q)) / longint'($signed(operand));
          egress_q = quot[31:0];
        end
        lever_q = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic result_t mill_predict(input logic [3:0] op, input logic [47:0] d);
    logic [9:0]  idx;
    logic [31:0] val;
    logic [1:0]  dir, cond;
    result_t     r;
    idx = d[9:0];
    val = d[41:10];
    dir = d[43:42];
    cond = d[45:44];
    r = '0;
    r.jump_offset = 32'd1;
    if (!halted_q) begin
      case (op)
        OP_NUMBER: mem_q[idx] = val;
        OP_ADD:    mode_q = MODE_ADD;
        OP_SUB:    mode_q = MODE_SUB;
        OP_MUL:    mode_q = MODE_MUL;
        OP_DIV:    mode_q = MODE_DIV;
        OP_LOAD, OP_LOADZ: begin
          if (!phase_q) ingress_q = mem_q[idx];
          else mill_calc(mem_q[idx]);
          phase_q = !phase_q;
          if (op == OP_LOADZ) mem_q[idx] = 32'd0;
        end
        OP_STORE:  mem_q[idx] = egress_q;
        OP_JUMP: begin
          if (cond == COND_ALWAYS || (cond == COND_LEVER && lever_q)) begin
            r.jump_taken = 1'b1;
            if (dir == DIR_BACK) r.jump_offset = -val;
            else if (dir == DIR_FWD) r.jump_offset = val;
            else r.jump_offset = 32'd0;
          end
        end
        OP_BEEP:   r.beep = 1'b1;
        OP_HALT:   halted_q = 1'b1;
        OP_PRINT:  r.print_valid = 1'b1;
        default: ;
      endcase
    end
    r.egress_value = egress_q;
    r.halted = halted_q;
    r.lever = lever_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      foreach (mem_q[i]) mem_q[i] = 32'd0;
      ingress_q = '0;
      egress_q = '0;
      limit_q = LeverLimitReset;
      phase_q = 1'b0;
      lever_q = 1'b0;
      halted_q = 1'b0;
      mode_q = MODE_NULL;
      result_q.delete();
      err_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(mill_predict(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report("unexpected transfer", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[31:0] !== want.egress_value)
            report("egress_value", m_axis_tdata[31:0], want.egress_value);
          if (m_axis_tdata[63:32] !== want.jump_offset)
            report("jump_offset", m_axis_tdata[63:32], want.jump_offset);
          if (m_axis_tuser[0] !== want.print_valid)
            report("print_valid", 32'(m_axis_tuser[0]), 32'(want.print_valid));
          if (m_axis_tuser[1] !== want.beep)
            report("beep", 32'(m_axis_tuser[1]), 32'(want.beep));
          if (m_axis_tuser[2] !== want.halted)
            report("halted", 32'(m_axis_tuser[2]), 32'(want.halted));
          if (m_axis_tuser[3] !== want.jump_taken)
            report("jump_taken", 32'(m_axis_tuser[3]), 32'(want.jump_taken));
          if (m_axis_tuser[4] !== want.lever)
            report("lever", 32'(m_axis_tuser[4]), 32'(want.lever));
        end
      end
    end
    pending_o <= result_q.size();
    errors_o <= err_cnt;
  end
endmodule

// ===== verif/card_driven_mill_executor_top_tb.sv =====
// Testbench top for the card-driven mill: card stimulus, result stalls, config phases, verdict.
`timescale 1ns / 1ps
module card_driven_mill_executor_top_tb;
  import cdme_pkg::*;

  localparam logic [3:0] OP_NOP = 4'd12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  int          pending, errors;
  logic        busy_run = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  card_driven_mill_executor_top DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  card_driven_mill_executor_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .pending_o(pending), .errors_o(errors)
  );

  initial begin
    #2_000_000;
    $display("card_driven_mill_executor_top: mismatch");
    $finish;
  end

  // result side stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = busy_run ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic card(input logic [3:0] op, input logic [9:0] idx, input logic [31:0] val,
                      input logic [1:0] dir = 2'd0, input logic [1:0] cond = 2'd0);
    int gap;
    gap = busy_run ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'd0, cond, dir, val, idx};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain_and_config(input logic [31:0] limit);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= limit;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] limit);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 120) - 60;
      2: return 32'd0;
      3: case ($urandom_range(0, 2))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           default: return 32'hffff_ffff;
         endcase
      4: return limit + $urandom_range(0, 4) - 2;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // one calculation sequence with random content; returns cards sent
  task automatic mill_sequence(input logic [31:0] limit, output int sent);
    int k;
    sent = 0;
    k = $urandom_range(1, 3);
    repeat (k) begin
      card(OP_NUMBER, 10'($urandom_range(0, 7)), pick_value(limit));
      sent++;
    end
    if ($urandom_range(0, 5) != 0) begin
      card(4'($urandom_range(OP_ADD, OP_DIV)), 0, $urandom);
      sent++;
    end
    repeat (2) begin
      card($urandom_range(0, 3) == 0 ? OP_LOADZ : OP_LOAD,
           $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 7)), $urandom);
      sent++;
    end
    if ($urandom_range(0, 1)) begin
      card(OP_STORE, 10'($urandom_range(0, 7)), $urandom);
      sent++;
    end
    card(OP_JUMP, 10'($urandom), pick_value(limit), 2'($urandom), 2'($urandom));
    sent++;
    case ($urandom_range(0, 3))
      0: begin card(OP_PRINT, 10'($urandom), $urandom); sent++; end
      1: begin card(OP_BEEP, 10'($urandom), $urandom); sent++; end
      2: begin card(4'($urandom_range(OP_NOP, 15)), 10'($urandom), $urandom); sent++; end
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] limits [5];
    logic [3:0]  op;
    int          sent, total;
    limits[0] = 32'h8000_0000;
    limits[1] = 32'h7fff_ffff;
    limits[2] = 32'd0;
    limits[3] = $urandom_range(0, 200);
    limits[4] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: null-mode calc, add overflow, div overflow, div by zero, jumps, flags
    card(OP_LOAD, 0, 0);
    card(OP_LOAD, 1, 0);
    card(OP_NUMBER, 0, 32'h7fff_ffff);
    card(OP_NUMBER, 1023, 32'h8000_0000);
    card(OP_NUMBER, 1, 32'd1);
    card(OP_ADD, 0, 0);
    card(OP_LOAD, 0, 0);
    card(OP_LOAD, 1, 0);
    card(OP_STORE, 2, 0);
    card(OP_NUMBER, 3, 32'hffff_ffff);
    card(OP_DIV, 0, 0);
    card(OP_LOAD, 1023, 0);
    card(OP_LOADZ, 3, 0);
    card(OP_LOADZ, 2, 0);
    card(OP_LOAD, 3, 0);
    card(OP_SUB, 0, 0);
    card(OP_LOAD, 1, 0);
    card(OP_LOAD, 0, 0);
    card(OP_JUMP, 0, 32'd5, DIR_BACK, COND_LEVER);
    card(OP_JUMP, 0, 32'h8000_0000, DIR_FWD, COND_ALWAYS);
    card(OP_JUMP, 0, 32'd9, 2'd3, 2'd3);
    card(OP_JUMP, 0, 32'd9, 2'd0, 2'd2);
    card(OP_BEEP, 0, 0);
    card(OP_PRINT, 0, 0);
    card(4'd15, 10'h3ff, 32'hffff_ffff, 2'd3, 2'd3);

    total = 0;
    foreach (limits[p]) begin
      drain_and_config(limits[p]);
      busy_run = (p == 1);
      while (total < 135 * (p + 1)) begin
        if ($urandom_range(0, 7) == 0) begin
          op = 4'($urandom_range(0, 15));
          if (op == OP_HALT) op = OP_NOP;
          card(op, 10'($urandom), $urandom, 2'($urandom), 2'($urandom));
          total++;
        end else begin
          mill_sequence(limits[p], sent);
          total += sent;
        end
      end
      busy_run = 1'b0;
    end

    card(OP_HALT, 0, 0);
    repeat (6) card(4'($urandom_range(0, 15)), 10'($urandom), $urandom, 2'($urandom),
                    2'($urandom));

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("card_driven_mill_executor_top: match");
    end else begin
      $display("card_driven_mill_executor_top: mismatch");
    end
    $finish;
  end
endmodule
